// ===== design/rc4_pkg.sv =====
// Shared constants for the RC4 stream cipher: permutation size, key store
// defaults and the item mode codes. No dependencies.
package rc4_pkg;

  localparam int PERM_DEPTH      = 256;
  localparam int MAX_KEY_BYTES_D = 256;

  localparam logic [8:0] KEY_LEN_RESET = 9'd16;
  localparam logic [7:0] PERM_LAST     = 8'(PERM_DEPTH - 1);

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

endpackage

// ===== design/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: key store and permutation in two rc4_ram
// instances, key schedule and data byte sequencer. Depends on rc4_pkg, rc4_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: in_mode, in_key_index,
//   in_byte_value. Mode 0 writes a key byte, mode 1 runs the key schedule,
//   mode 2 ciphers one data byte, mode 3 is dropped. Only mode 2 gives a
//   result word on the output channel (out_valid / out_stall, out_byte).
//   cfg_we / cfg_wdata set key_length; write it only while the block is idle.
// Sequencing:
//   A key byte is written as its word is accepted. Key schedule: identity fill
//   of the permutation, then states KA, KB, KC, KD for each permutation entry,
//   paced by the single write port of the permutation RAM. Data byte: states
//   S_D2, S_D3, set by the chain of dependent permutation reads (S[i], S[j],
//   S[S[i]+S[j]]); back in S_IDLE, the result loads as the next word is accepted.
// Reset: indices clear, key_length returns to 16, output empties. Permutation
//   and key store are not cleared; run a key schedule before data bytes.
// Stall: a result waiting in the output register holds while out_stall is
//   high; a following result then holds in_stall high until it can move up.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_key_index,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  localparam int         KAW     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [8:0] MAX_LEN = 9'(MAX_KEY_BYTES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_IDENT = 8'b0000_0010,
    S_KA    = 8'b0000_0100,
    S_KB    = 8'b0000_1000,
    S_KC    = 8'b0001_0000,
    S_KD    = 8'b0010_0000,
    S_D2    = 8'b0100_0000,
    S_D3    = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [7:0]     n_r, n_nxt;
  logic [7:0]     acc_r, acc_nxt;
  logic [7:0]     held_r, held_nxt;
  logic [KAW-1:0] pos_r, pos_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [7:0]     a_r, a_nxt;
  logic [7:0]     b_r, b_nxt;
  logic [7:0]     t_r, t_nxt;
  logic           hit_r, hit_nxt;
  logic [7:0]     data_r, data_nxt;
  logic           res_pend_r, res_pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic [8:0]     key_len_r;

  logic           in_acc;
  logic           out_blocked;
  logic           res_load;
  logic [8:0]     len_eff;
  logic [8:0]     pos_inc;
  logic [7:0]     sum_t;

  logic           p_we;
  logic [7:0]     p_waddr, p_wdata, p_raddr, p_rd;
  logic           k_we;
  logic [7:0]     k_rd;

  rc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rd)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key (
    .clk     (clk),
    .wr_en   (k_we),
    .wr_addr (in_key_index[KAW-1:0]),
    .wr_data (in_byte_value),
    .rd_addr (pos_r),
    .rd_data (k_rd)
  );

  assign out_blocked = out_valid_r && out_stall;
  assign in_stall    = (state_r != S_IDLE) || (res_pend_r && out_blocked);
  assign in_acc      = in_valid && !in_stall;
  assign res_load    = (state_r == S_IDLE) && res_pend_r && !out_blocked;
  assign k_we        = in_acc && (in_mode == MODE_KEY) && ({1'b0, in_key_index} < MAX_LEN);
  assign len_eff     = (key_len_r > MAX_LEN) ? MAX_LEN : key_len_r;
  assign pos_inc     = 9'(pos_r) + 9'd1;
  assign sum_t       = a_r + p_rd;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    held_nxt      = held_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    hit_nxt       = hit_r;
    data_nxt      = data_r;
    res_pend_nxt  = res_pend_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    p_we          = 1'b0;
    p_waddr       = n_r;
    p_wdata       = n_r;
    p_raddr       = t_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = data_r ^ (hit_r ? b_r : p_rd);
      res_pend_nxt  = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_SCHED)) begin
          n_nxt     = '0;
          state_nxt = S_IDENT;
        end else if (in_acc && (in_mode == MODE_DATA)) begin
          i_nxt     = i_r + 8'd1;
          p_raddr   = i_r + 8'd1;
          data_nxt  = in_byte_value;
          state_nxt = S_D2;
        end
      end
      S_IDENT: begin
        p_we = 1'b1;
        if (n_r == PERM_LAST) begin
          n_nxt     = '0;
          acc_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = S_KA;
        end else begin
          n_nxt = n_r + 8'd1;
        end
      end
      S_KA: begin
        p_raddr   = n_r;
        state_nxt = S_KB;
      end
      S_KB: begin
        held_nxt  = p_rd;
        acc_nxt   = acc_r + p_rd + k_rd;
        p_raddr   = acc_r + p_rd + k_rd;
        pos_nxt   = (pos_inc >= len_eff) ? '0 : KAW'(pos_inc);
        state_nxt = S_KC;
      end
      S_KC: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = p_rd;
        state_nxt = S_KD;
      end
      S_KD: begin
        p_we    = 1'b1;
        p_waddr = acc_r;
        p_wdata = held_r;
        if (n_r == PERM_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          n_nxt     = n_r + 8'd1;
          state_nxt = S_KA;
        end
      end
      S_D2: begin
        a_nxt     = p_rd;
        j_nxt     = j_r + p_rd;
        p_raddr   = j_r + p_rd;
        p_we      = 1'b1;
        p_waddr   = j_r + p_rd;
        p_wdata   = p_rd;
        state_nxt = S_D3;
      end
      S_D3: begin
        b_nxt        = p_rd;
        p_we         = 1'b1;
        p_waddr      = i_r;
        p_wdata      = p_rd;
        p_raddr      = sum_t;
        t_nxt        = sum_t;
        hit_nxt      = (sum_t == i_r);
        res_pend_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_len_r   <= KEY_LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      res_pend_r  <= res_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        key_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    held_r     <= held_nxt;
    pos_r      <= pos_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    hit_r      <= hit_nxt;
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

`ifndef NO_ASSERTIONS
  a_out_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_pend_r))
    else $error("result word appeared without a pending result");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while sequencer busy");

  a_sched_clears_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KD && n_r == PERM_LAST) |=> (i_r == 8'd0 && j_r == 8'd0))
    else $error("indices not cleared at end of key schedule");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_pend_r && out_blocked) |=> res_pend_r)
    else $error("pending result lost while output stalled");
`endif

endmodule

// ===== design/rc4_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== dv/rc4_keystream_checker.sv =====
`timescale 1ns / 1ps
// Keystream checker for rc4_stream_cipher: watches the word, result and config
// ports, keeps its own permutation and key bytes, and compares every result
// word. Depends on rc4_pkg.
module rc4_keystream_checker
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_key_index,
  input  logic [7:0] in_byte_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  logic [7:0] sbox[PERM_DEPTH];
  logic [7:0] key_mem[MAX_KEY_BYTES_D];
  logic [7:0] ci, cj;
  logic [8:0] sched_len;
  logic [7:0] out_bytes_due[$];

  function automatic void flag_error(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : watch
    int span;
    int pos;
    logic [7:0] acc, held, a, b, ks_at, due;
    if (!rst_n) begin
      ci = '0;
      cj = '0;
      sched_len = KEY_LEN_RESET;
      out_bytes_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) sched_len = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (out_bytes_due.size() == 0) begin
          flag_error($sformatf("out_byte %02h with no data word pending", out_byte));
        end else begin
          due = out_bytes_due.pop_front();
          if (out_byte !== due)
            flag_error($sformatf("out_byte mismatch: expected %02h, got %02h", due, out_byte));
        end
      end
      if (in_valid && !in_stall) begin
        case (in_mode)
          MODE_KEY: begin
            key_mem[in_key_index] = in_byte_value;
          end
          MODE_SCHED: begin
            span = (sched_len > MAX_KEY_BYTES_D) ? MAX_KEY_BYTES_D : int'(sched_len);
            pos = 0;
            acc = '0;
            for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = 8'(n);
            for (int n = 0; n < PERM_DEPTH; n++) begin
              held = sbox[n];
              acc = acc + held + key_mem[pos];
              sbox[n] = sbox[acc];
              sbox[acc] = held;
              pos = (pos + 1 >= span) ? 0 : pos + 1;
            end
            ci = '0;
            cj = '0;
          end
          MODE_DATA: begin
            ci = ci + 8'd1;
            a = sbox[ci];
            cj = cj + a;
            b = sbox[cj];
            sbox[ci] = b;
            sbox[cj] = a;
            ks_at = a + b;
            out_bytes_due.push_back(in_byte_value ^ sbox[ks_at]);
          end
          default: ;
        endcase
      end
    end
    pending = out_bytes_due.size();
  end

endmodule

// ===== dv/rc4_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
// rc4_stream_cipher testbench top: clock, reset, key/schedule/data word stimulus,
// result stall and verdict. Depends on rc4_pkg, rc4_stream_cipher, rc4_keystream_checker.
module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int SCHED_CYCLES = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_mode;
  logic [7:0] in_key_index;
  logic [7:0] in_byte_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         fails;
  int         pending;

  logic         jitter = 1'b0;
  logic         hold_req = 1'b0;
  logic [255:0] key_known;

  rc4_stream_cipher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_key_index (in_key_index),
    .in_byte_value(in_byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  rc4_keystream_checker ks_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_key_index (in_key_index),
    .in_byte_value(in_byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fails),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[rc4_stream_cipher] ERROR");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [1:0] mode, input logic [7:0] idx,
                           input logic [7:0] val);
    int gap;
    @(negedge clk);
    gap = jitter ? idle_len() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_key_index = idx;
    in_byte_value = val;
    do @(posedge clk); while (in_stall);
    if (mode == MODE_KEY) key_known[idx] = 1'b1;
  endtask

  task automatic set_key_length(input logic [8:0] len);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] len, input int count, input logic squeeze);
    int span;
    int r;
    set_key_length(len);
    span = (len == 0) ? 1 : ((len > MAX_KEY_BYTES_D) ? MAX_KEY_BYTES_D : int'(len));
    for (int k = 0; k < span; k++)
      if (!key_known[k]) send_word(MODE_KEY, 8'(k), 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 4))
      send_word(MODE_KEY, 8'($urandom_range(0, span - 1)), 8'($urandom_range(0, 255)));
    send_word(MODE_SCHED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    if (squeeze) hold_req = 1'b1;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 82)
        send_word(MODE_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (r < 89)
        send_word(MODE_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (r < 94)
        send_word(MODE_IGNORED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        send_word(MODE_SCHED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (jitter && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    logic [8:0] lengths[NUM_PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_KEY;
    in_key_index = '0;
    in_byte_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_known = '0;
    lengths = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd5, KEY_LEN_RESET,
                9'd0, 9'd0, 9'd0};
    lengths[7] = 9'($urandom_range(1, 511));
    lengths[8] = 9'($urandom_range(1, 64));
    lengths[9] = 9'($urandom_range(2, 300));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    jitter = 1'b1;
    set_key_length(9'd3);
    send_word(MODE_KEY, 8'h00, 8'h00);
    send_word(MODE_KEY, 8'h01, 8'hFF);
    send_word(MODE_KEY, 8'h02, 8'h5A);
    send_word(MODE_KEY, 8'hFF, 8'hAA);
    send_word(MODE_IGNORED, 8'hFF, 8'hFF);
    send_word(MODE_SCHED, 8'h00, 8'h00);
    send_word(MODE_DATA, 8'h00, 8'h00);
    send_word(MODE_DATA, 8'hFF, 8'hFF);
    send_word(MODE_DATA, 8'h00, 8'h55);
    send_word(MODE_DATA, 8'h00, 8'hAA);
    send_word(MODE_IGNORED, 8'h00, 8'h00);
    send_word(MODE_SCHED, 8'hFF, 8'hFF);
    send_word(MODE_DATA, 8'h00, 8'h01);
    send_word(MODE_DATA, 8'h00, 8'h80);
    send_word(MODE_DATA, 8'h00, 8'hFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      jitter = ($urandom_range(0, 4) != 0);
      run_phase(lengths[p], (p == 3) ? 320 : $urandom_range(15, 50), p == 3);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[rc4_stream_cipher] OK");
    end else begin
      $display("[rc4_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
